[hw/rtl/text_console_cursor_engine_macros.svh]
// Assertion helpers for the text console cursor engine.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is high.
`define TCCE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TCCE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TCCE_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define TCCE_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[hw/rtl/tcce_pkg.sv]
`default_nettype none

package tcce_pkg;

   // Default limits on the configured screen size.
   localparam int MAX_COLUMNS_DEF = 256;
   localparam int MAX_ROWS_DEF    = 128;

   // Register reset values.
   localparam int COLUMNS_RESET = 80;
   localparam int ROWS_RESET    = 25;

   // Field widths.
   localparam int COLUMNS_REG_W = 9;
   localparam int ROWS_REG_W    = 8;
   localparam int COLOUR_W      = 24;
   localparam int CHAR_W        = 8;
   localparam int COMMAND_W     = 2;
   localparam int COL_FIELD_W   = 9;
   localparam int ROW_FIELD_W   = 8;
   localparam int CSR_INDEX_W   = 2;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;

   // Commands per item: a tab gives four draws, each possibly preceded by a scroll.
   localparam int TAB_SPACES = 4;
   localparam int MAX_CMDS   = 2 * TAB_SPACES;
   localparam int CNT_W      = $clog2(MAX_CMDS + 1);
   localparam int IDX_W      = $clog2(MAX_CMDS);

   // Control characters.
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_DRAW   = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_SCROLL = 2'd2
   } command_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEXT_COLUMNS = 2'd0,
      CSR_TEXT_ROWS    = 2'd1,
      CSR_BACKGROUND   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                   last;
      logic [COLOUR_W-1:0]    colour;
      logic [CHAR_W-1:0]      glyph;
      logic [ROW_FIELD_W-1:0] row;
      logic [COL_FIELD_W-1:0] column;
      command_type            command;
   } cmd_type;

   function automatic cmd_type mk_cmd(
      input command_type            command,
      input logic [COL_FIELD_W-1:0] column,
      input logic [ROW_FIELD_W-1:0] row,
      input logic [CHAR_W-1:0]      glyph,
      input logic [COLOUR_W-1:0]    colour
   );
      cmd_type c;
      c.last    = 1'b0;
      c.colour  = colour;
      c.glyph   = glyph;
      c.row     = row;
      c.column  = column;
      c.command = command;
      return c;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/tcce_cmd_gen.sv]
`default_nettype none

// Turns one character into its command list and the cursor that follows.
module tcce_cmd_gen #(
   parameter int MAX_COLUMNS = tcce_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = tcce_pkg::MAX_ROWS_DEF,
   parameter int CW          = $clog2(MAX_COLUMNS + 2),
   parameter int RW          = $clog2(MAX_ROWS + 1)
) (
   input  wire logic [CW-1:0]                   cur_col,
   input  wire logic [RW-1:0]                   cur_row,
   input  wire logic [CW-1:0]                   cols_eff,
   input  wire logic [RW-1:0]                   rows_eff,
   input  wire logic [tcce_pkg::COLOUR_W-1:0]   background,
   input  wire logic [tcce_pkg::CHAR_W-1:0]     char_code,
   input  wire logic [tcce_pkg::COLOUR_W-1:0]   ink_colour,
   output      logic [CW-1:0]                   next_col,
   output      logic [RW-1:0]                   next_row,
   output      tcce_pkg::cmd_type [tcce_pkg::MAX_CMDS-1:0] cmd_list,
   output      logic [tcce_pkg::CNT_W-1:0]      cmd_count
);
   import tcce_pkg::*;

   typedef struct packed {
      logic [CW-1:0] col;
      logic [RW-1:0] row;
      logic          scroll;
   } pos_type;

   // One cursor advance: wrap past the column count, clamp and scroll at the row count.
   function automatic pos_type advance(input pos_type p, input logic [CW-1:0] cols,
                                       input logic [RW-1:0] rows);
      pos_type     q;
      logic [RW:0] r;
      r        = {1'b0, p.row};
      q.scroll = 1'b0;
      if (p.col > cols) begin
         q.col = '0;
         r     = r + 1'b1;
      end else begin
         q.col = p.col + 1'b1;
      end
      if (r >= {1'b0, rows}) begin
         r        = {1'b0, rows} - 1'b1;
         q.scroll = 1'b1;
      end
      q.row = r[RW-1:0];
      return q;
   endfunction

   always_comb begin
      pos_type                p;
      logic [CNT_W-1:0]       n;
      logic [CW-1:0]          bcol;
      logic [RW-1:0]          brow;
      logic                   is_tab;
      logic [CHAR_W-1:0]      glyph;
      cmd_type                scroll_cmd;

      p.col      = cur_col;
      p.row      = cur_row;
      p.scroll   = 1'b0;
      n          = '0;
      cmd_list   = '0;
      bcol       = cur_col - 1'b1;
      brow       = cur_row;
      is_tab     = (char_code == CHAR_TAB);
      glyph      = is_tab ? CHAR_SPACE : char_code;
      scroll_cmd = mk_cmd(CMD_SCROLL, '0, '0, '0, background);

      if (char_code == CHAR_NEWLINE) begin
         p = advance(p, cols_eff, rows_eff);
         if (p.scroll) begin
            cmd_list[n[IDX_W-1:0]] = scroll_cmd;
            n = n + 1'b1;
         end
         p.col = '0;
         p.row = p.row + 1'b1;
      end else if (char_code == CHAR_RETURN) begin
         p.col = '0;
      end else if (char_code == CHAR_BACKSPACE && cur_col != '0) begin
         // Step back; at the line start go to the previous row's last cell, or to column 0 if that row is row 0.
         if (bcol == '0) begin
            bcol = cols_eff - 1'b1;
            if (brow != '0) begin
               brow = brow - 1'b1;
            end
            if (brow == '0) begin
               bcol = '0;
            end
         end
         p.col = bcol;
         p.row = brow;
         cmd_list[n[IDX_W-1:0]] = mk_cmd(CMD_CLEAR, COL_FIELD_W'(bcol + 1'b1),
                                         ROW_FIELD_W'(brow), '0, background);
         n = n + 1'b1;
      end else begin
         for (int i = 0; i < TAB_SPACES; i++) begin
            if (i == 0 || is_tab) begin
               p = advance(p, cols_eff, rows_eff);
               if (p.scroll) begin
                  cmd_list[n[IDX_W-1:0]] = scroll_cmd;
                  n = n + 1'b1;
               end
               cmd_list[n[IDX_W-1:0]] = mk_cmd(CMD_DRAW, COL_FIELD_W'(p.col),
                                               ROW_FIELD_W'(p.row), glyph, ink_colour);
               n = n + 1'b1;
            end
         end
      end

      if (n != '0) begin
         cmd_list[IDX_W'(n - 1'b1)].last = 1'b1;
      end

      next_col  = p.col;
      next_row  = p.row;
      cmd_count = n;
   end

endmodule

`default_nettype wire

[hw/rtl/text_console_cursor_engine.sv]
// A character waits in the input register until its commands load into the command buffer,
// whose head drives rsp. Throughput: one character per cycle while each gives at most one
// command and rsp_tready stays high; a longer run (up to eight commands for a tab) leaves
// the command buffer one entry a cycle while rsp_tready is high, and the next character waits.
// Reset (synchronous, active high): cursor at column 0 row 0, 80 columns, 25 rows,
// black background, input register and command buffer empty.
`default_nettype none

`include "text_console_cursor_engine_macros.svh"

module text_console_cursor_engine #(
   parameter int MAX_COLUMNS = tcce_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = tcce_pkg::MAX_ROWS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Character channel.
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // [7:0] char_code, [31:8] ink_colour
   input  wire logic [tcce_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Command channel.
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [1:0] command, [10:2] cell_column, [18:11] cell_row, [26:19] glyph_code,
   // [50:27] cell_colour, [55:51] zero
   output      logic [tcce_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output      logic                               rsp_tlast,  // last_of_run
   // Register writes.
   input  wire logic                               csr_we,
   input  wire logic [tcce_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [tcce_pkg::COLOUR_W-1:0]      csr_wdata
);
   import tcce_pkg::*;

   // Cursor column may sit one past the column count; the row may reach the row count.
   localparam int CW = $clog2(MAX_COLUMNS + 2);
   localparam int RW = $clog2(MAX_ROWS + 1);

   localparam int COLS_RESET_SAT = (COLUMNS_RESET > MAX_COLUMNS) ? MAX_COLUMNS : COLUMNS_RESET;
   localparam int ROWS_RESET_SAT = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;

   // ---------------------------------------------------------------------
   // Configuration: store counts already clamped to 1..MAX.
   // ---------------------------------------------------------------------
   logic [CW-1:0]        cols_eff_ff, cols_eff_in;
   logic [RW-1:0]        rows_eff_ff, rows_eff_in;
   logic [COLOUR_W-1:0]  background_ff, background_in;
   logic [COLUMNS_REG_W-1:0] wr_cols;
   logic [ROWS_REG_W-1:0]    wr_rows;
   logic [CW-1:0]        cols_sat;
   logic [RW-1:0]        rows_sat;

   always_comb begin
      wr_cols = csr_wdata[COLUMNS_REG_W-1:0];
      wr_rows = csr_wdata[ROWS_REG_W-1:0];

      if (wr_cols == '0) begin
         cols_sat = CW'(1);
      end else if (32'(wr_cols) > 32'(MAX_COLUMNS)) begin
         cols_sat = CW'(MAX_COLUMNS);
      end else begin
         cols_sat = CW'(wr_cols);
      end

      if (wr_rows == '0) begin
         rows_sat = RW'(1);
      end else if (32'(wr_rows) > 32'(MAX_ROWS)) begin
         rows_sat = RW'(MAX_ROWS);
      end else begin
         rows_sat = RW'(wr_rows);
      end

      cols_eff_in   = cols_eff_ff;
      rows_eff_in   = rows_eff_ff;
      background_in = background_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TEXT_COLUMNS: cols_eff_in   = cols_sat;
            CSR_TEXT_ROWS:    rows_eff_in   = rows_sat;
            CSR_BACKGROUND:   background_in = csr_wdata;
            default:          ;  // unused index: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Input register and command buffer handshake.
   // ---------------------------------------------------------------------
   logic                 item_valid_ff, item_valid_in;
   logic [REQ_DATA_W-1:0] item_ff, item_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   cmd_type [MAX_CMDS-1:0] entries_ff, entries_in;
   logic [CW-1:0]        cursor_col_ff, cursor_col_in;
   logic [RW-1:0]        cursor_row_ff, cursor_row_in;

   logic                 rsp_xfer;
   logic                 load;
   logic [CW-1:0]        gen_col;
   logic [RW-1:0]        gen_row;
   cmd_type [MAX_CMDS-1:0] gen_list;
   logic [CNT_W-1:0]     gen_count;

   tcce_cmd_gen #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .CW          (CW),
      .RW          (RW)
   ) u_cmd_gen (
      .cur_col    (cursor_col_ff),
      .cur_row    (cursor_row_ff),
      .cols_eff   (cols_eff_ff),
      .rows_eff   (rows_eff_ff),
      .background (background_ff),
      .char_code  (item_ff[CHAR_W-1:0]),
      .ink_colour (item_ff[CHAR_W +: COLOUR_W]),
      .next_col   (gen_col),
      .next_row   (gen_row),
      .cmd_list   (gen_list),
      .cmd_count  (gen_count)
   );

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   // Load the held character once the buffer is empty or gives up its final entry now.
   assign load       = item_valid_ff && ((count_ff == '0) ||
                                         (count_ff == CNT_W'(1) && rsp_tready));
   assign req_tready = !item_valid_ff || load;

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      count_in      = count_ff;
      entries_in    = entries_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;

      if (load) begin
         // Replace the buffer with the new run and advance the cursor.
         entries_in    = gen_list;
         count_in      = gen_count;
         cursor_col_in = gen_col;
         cursor_row_in = gen_row;
         item_valid_in = 1'b0;
      end else if (rsp_xfer) begin
         // Shift the buffer down one entry per transfer.
         for (int i = 0; i < MAX_CMDS - 1; i++) begin
            entries_in[i] = entries_ff[i+1];
         end
         count_in = count_ff - 1'b1;
      end

      if (req_tvalid && req_tready) begin
         item_in       = req_tdata;
         item_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_eff_ff   <= CW'(COLS_RESET_SAT);
         rows_eff_ff   <= RW'(ROWS_RESET_SAT);
         background_ff <= '0;
         item_valid_ff <= 1'b0;
         count_ff      <= '0;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
      end else begin
         cols_eff_ff   <= cols_eff_in;
         rows_eff_ff   <= rows_eff_in;
         background_ff <= background_in;
         item_valid_ff <= item_valid_in;
         count_ff      <= count_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

   // Payload: no reset needed.
   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      entries_ff <= entries_in;
   end

   // ---------------------------------------------------------------------
   // Output: the head of the buffer.
   // ---------------------------------------------------------------------
   assign rsp_tdata = {{(RSP_DATA_W - 51){1'b0}},
                       entries_ff[0].colour,
                       entries_ff[0].glyph,
                       entries_ff[0].row,
                       entries_ff[0].column,
                       entries_ff[0].command};
   assign rsp_tlast = entries_ff[0].last;

   // ---------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------
   `TCCE_ASSERT_NXT(a_stall_holds_count, clock, reset, rsp_tvalid && !rsp_tready,
                    count_ff == $past(count_ff), "buffer count moved while stalled")
   `TCCE_ASSERT_IMP(a_last_at_tail, clock, reset, rsp_tvalid,
                    rsp_tlast == (count_ff == CNT_W'(1)), "tlast not on final entry of run")
   `TCCE_ASSERT_NXT(a_run_continues, clock, reset, rsp_xfer && count_ff > CNT_W'(1),
                    rsp_tvalid, "run dropped before its final command")

endmodule

`default_nettype wire

[tb/sv/tb_text_console_cursor_engine.sv]
`default_nettype none

module tb_text_console_cursor_engine;
   import tcce_pkg::*;

   localparam int SETTLE_CYCLES  = 8;     // covers the input register and command buffer plus drain slack
   localparam int STALL_LIMIT    = 2000;  // cycles with no transfer before giving up
   localparam int RANDOM_PHASES  = 9;
   localparam int ITEMS_PER_PHASE = 50;

   // Directed table row kinds.
   typedef enum logic [0:0] {
      STEP_CHAR = 1'b0,
      STEP_REG  = 1'b1
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      csr_index_type reg_index;
      logic [23:0]   value;      // register data for STEP_REG, ink for STEP_CHAR
      logic [7:0]    code;
      bit            typed;      // expected command written out by hand
      cmd_type       typed_cmd;
   } console_step_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [COLOUR_W-1:0]    csr_wdata = '0;

   text_console_cursor_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Cursor predictor: register copies, cursor state, commands of one char.
   // ---------------------------------------------------------------------
   logic [COLUMNS_REG_W-1:0] screen_cols = 9'(COLUMNS_RESET);
   logic [ROWS_REG_W-1:0]    screen_rows = 8'(ROWS_RESET);
   logic [COLOUR_W-1:0]      back_colour = '0;
   logic [COL_FIELD_W-1:0]   cur_col = '0;
   logic [ROW_FIELD_W-1:0]   cur_row = '0;
   cmd_type                  step_cmds[$];
   cmd_type                  pending_cmds[$];   // commands still owed by the block

   int  error_count = 0;
   int  idle_cycles = 0;
   int  next_gap = 0;
   bit  valid_held = 1'b0;
   bit  source_calm = 1'b0;
   bit  sink_calm = 1'b0;
   int  stall_left = 0;
   cmd_type seen_cmd;
   cmd_type want_cmd;
   console_step_type directed_steps[$];

   // Zero counts act as one; oversized counts clip to the build limit.
   function automatic int eff_columns();
      int c;
      c = int'(screen_cols);
      if (c < 1) c = 1;
      if (c > MAX_COLUMNS_DEF) c = MAX_COLUMNS_DEF;
      return c;
   endfunction

   function automatic void add_cmd(command_type kind, logic [8:0] col, logic [7:0] row,
                                   logic [7:0] glyph, logic [23:0] colour);
      cmd_type c;
      if (step_cmds.size() >= MAX_CMDS) return;
      c.last    = 1'b0;
      c.colour  = colour;
      c.glyph   = glyph;
      c.row     = row;
      c.column  = col;
      c.command = kind;
      step_cmds.push_back(c);
   endfunction

   // Wrap past the last column, then clamp the row and scroll if it fell off.
   function automatic void advance_cursor();
      int rows;
      rows = int'(screen_rows);
      if (rows < 1) rows = 1;
      if (rows > MAX_ROWS_DEF) rows = MAX_ROWS_DEF;
      if (int'(cur_col) > eff_columns()) begin
         cur_col = '0;
         cur_row = cur_row + 8'd1;
      end else begin
         cur_col = cur_col + 9'd1;
      end
      if (int'(cur_row) >= rows) begin
         cur_row = 8'(rows - 1);
         add_cmd(CMD_SCROLL, 9'd0, 8'd0, 8'd0, back_colour);
      end
   endfunction

   function automatic void put_glyph(logic [7:0] code, logic [23:0] ink);
      advance_cursor();
      add_cmd(CMD_DRAW, cur_col, cur_row, code, ink);
   endfunction

   function automatic void console_step(logic [7:0] code, logic [23:0] ink);
      step_cmds.delete();
      if (code == CHAR_NEWLINE) begin
         advance_cursor();
         cur_col = '0;
         cur_row = cur_row + 8'd1;
      end else if (code == CHAR_RETURN) begin
         cur_col = '0;
      end else if (code == CHAR_TAB) begin
         repeat (TAB_SPACES) put_glyph(CHAR_SPACE, ink);
      end else if (code == CHAR_BACKSPACE && cur_col != '0) begin
         // Step back; landing on column 0 wraps to the end of the previous row, or to column 0 on row 0.
         cur_col = cur_col - 9'd1;
         if (cur_col == '0) begin
            cur_col = 9'(eff_columns() - 1);
            if (cur_row != '0) cur_row = cur_row - 8'd1;
            if (cur_row == '0) cur_col = '0;
         end
         add_cmd(CMD_CLEAR, cur_col + 9'd1, cur_row, 8'd0, back_colour);
      end else begin
         // Backspace at column 0 lands here and draws glyph 8.
         put_glyph(code, ink);
      end
      if (step_cmds.size() != 0) step_cmds[step_cmds.size() - 1].last = 1'b1;
   endfunction

   function automatic void flag_error(string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (source_calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Mostly plain text, with control characters frequent enough to matter.
   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 8'($urandom_range(32, 126));
      if (r < 57) return 8'($urandom_range(0, 255));
      if (r < 69) return CHAR_BACKSPACE;
      if (r < 80) return CHAR_NEWLINE;
      if (r < 86) return CHAR_RETURN;
      return CHAR_TAB;
   endfunction

   function automatic logic [23:0] pick_columns();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 24'($urandom_range(1, 12));
      if (r < 60) return 24'd0;
      if (r < 70) return 24'd256;
      if (r < 80) return 24'($urandom_range(257, 511));
      if (r < 85) return 24'($urandom());
      return 24'($urandom_range(13, 255));
   endfunction

   function automatic logic [23:0] pick_rows();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 24'($urandom_range(1, 6));
      if (r < 60) return 24'd0;
      if (r < 70) return 24'd128;
      if (r < 80) return 24'($urandom_range(129, 255));
      if (r < 85) return 24'($urandom());
      return 24'($urandom_range(7, 127));
   endfunction

   function automatic cmd_type solo(command_type kind, logic [8:0] col, logic [7:0] row,
                                    logic [7:0] glyph, logic [23:0] colour);
      cmd_type c;
      c.last    = 1'b1;
      c.colour  = colour;
      c.glyph   = glyph;
      c.row     = row;
      c.column  = col;
      c.command = kind;
      return c;
   endfunction

   function automatic void add_char(logic [7:0] code, logic [23:0] ink, bit typed = 1'b0,
                                    cmd_type typed_cmd = '0);
      console_step_type s;
      s.kind      = STEP_CHAR;
      s.reg_index = CSR_TEXT_COLUMNS;
      s.value     = ink;
      s.code      = code;
      s.typed     = typed;
      s.typed_cmd = typed_cmd;
      directed_steps.push_back(s);
   endfunction

   function automatic void add_reg(csr_index_type idx, logic [23:0] value);
      console_step_type s;
      s.kind      = STEP_REG;
      s.reg_index = idx;
      s.value     = value;
      s.code      = '0;
      s.typed     = 1'b0;
      s.typed_cmd = '0;
      directed_steps.push_back(s);
   endfunction

   // Offer one character and predict its commands at the transfer edge. Valid
   // stays high across back-to-back items; otherwise drop it right away.
   task automatic send_char(input logic [7:0] code, input logic [23:0] ink,
                            input bit typed = 1'b0, input cmd_type typed_cmd = '0);
      if (next_gap != 0) repeat (next_gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {ink, code};
      do @(posedge clock); while (!req_tready);
      console_step(code, ink);
      if (typed) pending_cmds.push_back(typed_cmd);
      else foreach (step_cmds[i]) pending_cmds.push_back(step_cmds[i]);
      next_gap = pick_gap();
      if (next_gap != 0) req_tvalid <= 1'b0;
      valid_held = (next_gap == 0);
   endtask

   // Drop valid, wait for every owed command, then let the pipe empty.
   task automatic settle();
      if (valid_held) begin
         req_tvalid <= 1'b0;
         valid_held = 1'b0;
      end
      next_gap = 0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [23:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_TEXT_COLUMNS: screen_cols = value[COLUMNS_REG_W-1:0];
         CSR_TEXT_ROWS:    screen_rows = value[ROWS_REG_W-1:0];
         CSR_BACKGROUND:   back_colour = value;
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Command sink: random stalls, short mostly, with calm stretches.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!sink_calm && $urandom_range(0, 99) < 20) begin
         stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                    : $urandom_range(7, 29);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check each command transfer against the oldest owed command; watch for hangs.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen_cmd = cmd_type'({rsp_tlast, rsp_tdata[50:0]});
            if (pending_cmds.size() == 0) begin
               flag_error($sformatf("unexpected command: cmd=%0d col=%0d row=%0d glyph=%h colour=%h last=%b",
                  seen_cmd.command, seen_cmd.column, seen_cmd.row, seen_cmd.glyph,
                  seen_cmd.colour, seen_cmd.last));
            end else begin
               want_cmd = pending_cmds.pop_front();
               if (want_cmd.command !== seen_cmd.command || want_cmd.column !== seen_cmd.column ||
                   want_cmd.row !== seen_cmd.row || want_cmd.glyph !== seen_cmd.glyph ||
                   want_cmd.colour !== seen_cmd.colour || want_cmd.last !== seen_cmd.last)
                  flag_error($sformatf({"command mismatch: expected cmd=%0d col=%0d row=%0d ",
                     "glyph=%h colour=%h last=%b, got cmd=%0d col=%0d row=%0d glyph=%h ",
                     "colour=%h last=%b"},
                     want_cmd.command, want_cmd.column, want_cmd.row, want_cmd.glyph,
                     want_cmd.colour, want_cmd.last, seen_cmd.command, seen_cmd.column,
                     seen_cmd.row, seen_cmd.glyph, seen_cmd.colour, seen_cmd.last));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence: directed table, then random phases with fresh settings.
   // ---------------------------------------------------------------------
   initial begin
      int sent;
      int run;
      bit wrote;

      // Fresh after reset: 80 columns, 25 rows, black background.
      add_char(8'd65, 24'hFFFFFF, 1'b1, solo(CMD_DRAW, 9'd1, 8'd0, 8'd65, 24'hFFFFFF));
      add_char(8'd0, 24'h000000, 1'b1, solo(CMD_DRAW, 9'd2, 8'd0, 8'd0, 24'h000000));
      add_char(8'd255, 24'hA5A5A5, 1'b1, solo(CMD_DRAW, 9'd3, 8'd0, 8'd255, 24'hA5A5A5));
      add_char(CHAR_BACKSPACE, 24'h5A5A5A, 1'b1, solo(CMD_CLEAR, 9'd3, 8'd0, 8'd0, 24'h0));
      add_char(CHAR_RETURN, 24'h5A5A5A);
      // Backspace at column 0 draws the control code itself.
      add_char(CHAR_BACKSPACE, 24'h0F0F0F, 1'b1,
               solo(CMD_DRAW, 9'd1, 8'd0, CHAR_BACKSPACE, 24'h0F0F0F));
      add_char(CHAR_TAB, 24'h00FF00);
      add_char(CHAR_NEWLINE, 24'h000000);
      add_char(CHAR_BACKSPACE, 24'h123123);
      add_char(CHAR_BACKSPACE, 24'h321321);   // wraps back to row 0, column 0
      // Smallest screen: every few advances wrap and scroll.
      add_reg(CSR_BACKGROUND, 24'h123456);
      add_reg(CSR_TEXT_ROWS, 24'd1);
      add_reg(CSR_TEXT_COLUMNS, 24'd1);
      add_char(8'd120, 24'hC0FFEE);
      add_char(8'd121, 24'h00C0DE);
      add_char(8'd122, 24'hFACADE);
      add_char(CHAR_NEWLINE, 24'h000000);
      add_char(CHAR_NEWLINE, 24'h000000);
      add_char(CHAR_TAB, 24'h808080);
      // Zero counts behave as one.
      add_reg(CSR_TEXT_COLUMNS, 24'd0);
      add_reg(CSR_TEXT_ROWS, 24'd0);
      add_char(CHAR_TAB, 24'h7F7F7F);
      add_char(CHAR_BACKSPACE, 24'h010101);
      add_char(CHAR_NEWLINE, 24'h000000);
      // Oversized writes: masked to the field, then clipped to the build limit.
      add_reg(CSR_TEXT_COLUMNS, 24'hFFFFFF);
      add_reg(CSR_TEXT_ROWS, 24'h0000FF);
      add_reg(CSR_BACKGROUND, 24'hFFFFFF);
      add_char(8'd81, 24'h800000);
      add_char(CHAR_BACKSPACE, 24'h000001);
      add_char(CHAR_BACKSPACE, 24'h000002);
      add_char(CHAR_NEWLINE, 24'h000000);
      add_reg(CSR_TEXT_COLUMNS, 24'd256);
      add_reg(CSR_TEXT_ROWS, 24'd128);
      add_char(8'd126, 24'h3C3C3C);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_REG) begin
            settle();
            write_reg(directed_steps[i].reg_index, directed_steps[i].value);
         end else begin
            send_char(directed_steps[i].code, directed_steps[i].value,
                      directed_steps[i].typed, directed_steps[i].typed_cmd);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         wrote = 1'b0;
         if ($urandom_range(0, 1)) begin
            write_reg(CSR_TEXT_COLUMNS, pick_columns());
            wrote = 1'b1;
         end
         if ($urandom_range(0, 1)) begin
            write_reg(CSR_TEXT_ROWS, pick_rows());
            wrote = 1'b1;
         end
         if (!wrote || $urandom_range(0, 2) == 0)
            write_reg(CSR_BACKGROUND, ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'($urandom()));
         source_calm = ($urandom_range(0, 3) == 0);
         sink_calm <= ($urandom_range(0, 3) == 0);

         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0) begin
               // Walk the cursor back across row boundaries.
               run = $urandom_range(3, 12);
               repeat (run) send_char(CHAR_BACKSPACE, 24'($urandom()));
               sent += run;
            end else begin
               send_char(pick_char(), 24'($urandom()));
               sent++;
            end
         end
      end

      settle();
      if (error_count == 0 && pending_cmds.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
+incdir+hw/rtl
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_cmd_gen.sv
hw/rtl/text_console_cursor_engine.sv
tb/sv/tb_text_console_cursor_engine.sv
